>>> rtl/tlbp_pkg.sv
// ----------------------------------------------------------------------------
// tlbp_pkg
// Shared types and constants of the two-level branch predictor with BTB.
// ----------------------------------------------------------------------------
package tlbp_pkg;

	localparam int NUM_REGS = 7;
	localparam int PADDR_W  = 5;

	localparam logic [2:0] REG_INDEX_BITS   = 3'd0;
	localparam logic [2:0] REG_HISTORY_BITS = 3'd1;
	localparam logic [2:0] REG_TAG_BITS     = 3'd2;
	localparam logic [2:0] REG_DEFAULT      = 3'd3;
	localparam logic [2:0] REG_GLOBAL_HIST  = 3'd4;
	localparam logic [2:0] REG_GLOBAL_TABLE = 3'd5;
	localparam logic [2:0] REG_SHARE_MODE   = 3'd6;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	localparam logic [1:0] SHARE_PC2  = 2'd1;
	localparam logic [1:0] SHARE_PC16 = 2'd2;

	typedef struct packed {
		logic [2:0] index_bits;
		logic [3:0] history_bits;
		logic [4:0] tag_bits;
		logic [1:0] default_state;
		logic       global_history;
		logic       global_table;
		logic [1:0] share_mode;
	} cfg_t;

endpackage

>>> rtl/tlbp_if.sv
// ----------------------------------------------------------------------------
// tlbp_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlbp_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] pc;
	logic [31:0] target_pc;
	logic        taken;
	logic [31:0] predicted_target;

	modport source (output valid, opcode, pc, target_pc, taken, predicted_target,
		input ready);
	modport sink (input valid, opcode, pc, target_pc, taken, predicted_target,
		output ready);
endinterface

interface tlbp_rsp_if;
	logic        valid;
	logic        ready;
	logic        predicted_taken;
	logic [31:0] next_pc;
	logic [31:0] flush_count;
	logic [31:0] update_count;

	modport source (output valid, predicted_taken, next_pc, flush_count, update_count,
		input ready);
	modport sink (input valid, predicted_taken, next_pc, flush_count, update_count,
		output ready);
endinterface

>>> rtl/tlbp_ram.sv
// ----------------------------------------------------------------------------
// tlbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/tlbp_cfg.sv
// ----------------------------------------------------------------------------
// tlbp_cfg
// APB register file; any write to a listed register restarts the predictor.
// ----------------------------------------------------------------------------
module tlbp_cfg import tlbp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg,
	output logic               init
);
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign init   = wr && (idx < 3'(NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.index_bits     <= 3'd5;
			cfg.history_bits   <= 4'd8;
			cfg.tag_bits       <= 5'd30;
			cfg.default_state  <= 2'd1;
			cfg.global_history <= 1'b0;
			cfg.global_table   <= 1'b0;
			cfg.share_mode     <= 2'd0;
		end else if (wr) begin
			case (idx)
				REG_INDEX_BITS:   cfg.index_bits     <= pwdata[2:0];
				REG_HISTORY_BITS: cfg.history_bits   <= pwdata[3:0];
				REG_TAG_BITS:     cfg.tag_bits       <= pwdata[4:0];
				REG_DEFAULT:      cfg.default_state  <= pwdata[1:0];
				REG_GLOBAL_HIST:  cfg.global_history <= pwdata[0];
				REG_GLOBAL_TABLE: cfg.global_table   <= pwdata[0];
				REG_SHARE_MODE:   cfg.share_mode     <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_INDEX_BITS:   prdata = {29'd0, cfg.index_bits};
			REG_HISTORY_BITS: prdata = {28'd0, cfg.history_bits};
			REG_TAG_BITS:     prdata = {27'd0, cfg.tag_bits};
			REG_DEFAULT:      prdata = {30'd0, cfg.default_state};
			REG_GLOBAL_HIST:  prdata = {31'd0, cfg.global_history};
			REG_GLOBAL_TABLE: prdata = {31'd0, cfg.global_table};
			REG_SHARE_MODE:   prdata = {30'd0, cfg.share_mode};
			default:          prdata = 32'd0;
		endcase
	end
endmodule

>>> rtl/tlbp_core.sv
// ----------------------------------------------------------------------------
// tlbp_core
// Entry lookup, counter read-modify-write and row clearing sequencer.
// ----------------------------------------------------------------------------
module tlbp_core import tlbp_pkg::*; #(
	parameter int MAX_ENTRIES = 32,
	parameter int MAX_HISTORY = 8,
	parameter int MAX_TAG     = 30
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  init,
	tlbp_req_if.sink   req,
	tlbp_rsp_if.source rsp
);
	localparam int IB   = $clog2(MAX_ENTRIES + 1) - 1;
	localparam int IBW  = IB > 0 ? IB : 1;
	localparam int HW   = MAX_HISTORY;
	localparam int TW   = MAX_TAG > 0 ? MAX_TAG : 1;
	localparam int EW   = TW + 32 + HW;
	localparam int CAW  = IBW + HW;
	localparam int ROWS = 1 << HW;

	typedef enum logic [1:0] {S_IDLE, S_ENT, S_CLR, S_CNT} state_t;
	state_t state_q;

	logic [3:0]     ib, hb;
	logic [4:0]     tb;
	logic [IBW-1:0] idx_mask;
	logic [HW-1:0]  hmask;
	logic [31:0]    tmask;

	assign ib = ({1'b0, cfg.index_bits} < 4'(IB)) ? {1'b0, cfg.index_bits} : 4'(IB);
	assign hb = (cfg.history_bits < 4'(HW)) ? cfg.history_bits : 4'(HW);
	assign tb = (cfg.tag_bits < 5'(MAX_TAG)) ? cfg.tag_bits : 5'(MAX_TAG);
	assign idx_mask = IBW'((32'd1 << ib) - 32'd1);
	assign hmask    = HW'((32'd1 << hb) - 32'd1);
	assign tmask    = (32'd1 << tb) - 32'd1;

	logic           accept;
	logic [IBW-1:0] idx_c;
	logic [TW-1:0]  tag_c;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!rsp.valid || rsp.ready);
	assign idx_c = IBW'(req.pc >> 2) & idx_mask;
	assign tag_c = TW'((req.pc >> (6'd2 + 6'(ib))) & tmask);

	logic           op_q, tkn_q;
	logic [31:0]    pc_q, tgt_q, pred_q;
	logic [IBW-1:0] idx_q;
	logic [TW-1:0]  tag_q;

	logic [EW-1:0]  ent_rdata, ent_wdata;
	logic           ent_we;
	logic [TW-1:0]  e_tag;
	logic [31:0]    e_target;
	logic [HW-1:0]  e_hist;

	assign e_tag    = ent_rdata[EW-1 -: TW];
	assign e_target = ent_rdata[HW +: 32];
	assign e_hist   = ent_rdata[HW-1:0];

	tlbp_ram #(.WIDTH(EW), .DEPTH(1 << IBW)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (idx_q),
		.wdata (ent_wdata),
		.raddr (idx_c),
		.rdata (ent_rdata)
	);

	logic [MAX_ENTRIES-1:0] valid_q;
	logic [ROWS-1:0]        sv_q;
	logic [HW-1:0]          shist_q;
	logic [31:0]            flush_q, upd_q;

	logic           hit;
	logic [HW-1:0]  hsel, ent_hist_c, ci_c;
	logic [31:0]    xr;

	assign hit = valid_q[idx_q] && (e_tag == tag_q);
	assign ent_hist_c = hit ? e_hist : '0;
	assign hsel = cfg.global_history ? shist_q : ent_hist_c;

	always_comb begin
		xr = 32'd0;
		if (cfg.global_table) begin
			case (cfg.share_mode)
				SHARE_PC2:  xr = pc_q >> 2;
				SHARE_PC16: xr = pc_q >> 16;
				default:    xr = 32'd0;
			endcase
		end
	end

	assign ci_c = (hsel ^ HW'(xr)) & hmask;

	logic           hit_s1, dflt_s1;
	logic [HW-1:0]  ci_s1, ehist_s1;
	logic [31:0]    etgt_s1;
	logic [HW-1:0]  clr_q;

	logic [CAW-1:0] c_raddr, c_waddr;
	logic [1:0]     c_rdata, c_wdata, cval, cnew;
	logic           c_we;

	assign c_raddr = cfg.global_table ? {IBW'(0), ci_c} : {idx_q, ci_c};

	assign cval = (dflt_s1 || (cfg.global_table && !sv_q[ci_s1])) ?
		cfg.default_state : c_rdata;

	always_comb begin
		cnew = cval;
		if (tkn_q) begin
			if (cval != 2'd3) cnew = cval + 2'd1;
		end else if (cval != 2'd0) begin
			cnew = cval - 2'd1;
		end
	end

	always_comb begin
		c_we    = 1'b0;
		c_waddr = cfg.global_table ? {IBW'(0), ci_s1} : {idx_q, ci_s1};
		c_wdata = cnew;
		if (state_q == S_CLR) begin
			c_we    = 1'b1;
			c_waddr = {idx_q, clr_q};
			c_wdata = cfg.default_state;
		end else if (state_q == S_CNT && op_q == OP_UPDATE) begin
			c_we = 1'b1;
		end
	end

	tlbp_ram #(.WIDTH(2), .DEPTH(1 << CAW)) u_cnt_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	logic [HW-1:0] new_hist;
	logic          ptkn;
	logic [31:0]   pc4, actual;

	assign new_hist  = ((ehist_s1 << 1) & hmask) | HW'(tkn_q);
	assign ent_we    = (state_q == S_CNT) && (op_q == OP_UPDATE);
	assign ent_wdata = {tag_q, etgt_s1, new_hist};
	assign pc4       = pc_q + 32'd4;
	assign ptkn      = hit_s1 && cval[1];
	assign actual    = tkn_q ? tgt_q : pc4;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.opcode;
			pc_q   <= req.pc;
			tgt_q  <= req.target_pc;
			tkn_q  <= req.taken;
			pred_q <= req.predicted_target;
			idx_q  <= idx_c;
			tag_q  <= tag_c;
		end
		if (state_q == S_ENT) begin
			hit_s1   <= hit;
			ci_s1    <= ci_c;
			ehist_s1 <= ent_hist_c;
			etgt_s1  <= hit ? e_target : tgt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			sv_q    <= '0;
			shist_q <= '0;
			flush_q <= '0;
			upd_q   <= '0;
			dflt_s1 <= 1'b0;
			clr_q   <= '0;
			rsp.valid           <= 1'b0;
			rsp.predicted_taken <= 1'b0;
			rsp.next_pc         <= '0;
			rsp.flush_count     <= '0;
			rsp.update_count    <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			if (init) begin
				valid_q <= '0;
				sv_q    <= '0;
				shist_q <= '0;
				flush_q <= '0;
				upd_q   <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_ENT;
				end
				S_ENT: begin
					clr_q <= '0;
					if (op_q == OP_UPDATE && !hit && !cfg.global_table) begin
						dflt_s1 <= 1'b1;
						state_q <= S_CLR;
					end else begin
						dflt_s1 <= 1'b0;
						state_q <= S_CNT;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + HW'(1);
					if (&clr_q) state_q <= S_CNT;
				end
				S_CNT: begin
					rsp.valid <= 1'b1;
					if (op_q == OP_PREDICT) begin
						rsp.predicted_taken <= ptkn;
						rsp.next_pc         <= ptkn ? etgt_s1 : pc4;
						rsp.flush_count     <= flush_q;
						rsp.update_count    <= upd_q;
					end else begin
						valid_q[idx_q] <= 1'b1;
						if (cfg.global_table) sv_q[ci_s1] <= 1'b1;
						if (cfg.global_history) begin
							shist_q <= ((shist_q << 1) & hmask) | HW'(tkn_q);
						end
						upd_q   <= upd_q + 32'd1;
						flush_q <= flush_q + 32'(pred_q != actual);
						rsp.predicted_taken <= 1'b0;
						rsp.next_pc         <= '0;
						rsp.flush_count     <= flush_q + 32'(pred_q != actual);
						rsp.update_count    <= upd_q + 32'd1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/two_level_branch_predictor_btb_top.sv
// ----------------------------------------------------------------------------
// The response is registered after the entry read (S_ENT) and the counter
// read-modify-write (S_CNT); an update that allocates an entry with per-entry
// counter rows first clears that row in S_CLR through the counter memory's
// single write port; requests wait for S_IDLE and a free response slot.
// Reset: entries invalid, histories and counts zero, no clearing pass.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_btb_top import tlbp_pkg::*; #(
	parameter int MAX_ENTRIES = 32,
	parameter int MAX_HISTORY = 8,
	parameter int MAX_TAG     = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	tlbp_req_if.sink           req,
	tlbp_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	cfg_t cfg;
	logic init;

	tlbp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.init    (init)
	);

	tlbp_core #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_HISTORY (MAX_HISTORY),
		.MAX_TAG     (MAX_TAG)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.init   (init),
		.req    (req),
		.rsp    (rsp)
	);
endmodule
